/* hdl/tjcm_pkg.sv */
// Package for the tilt/joystick control mapper: widths, register indexes,
// wrap constants, the sideband type and the joystick clamp function.
// No dependencies.
`default_nettype none

package tjcm_pkg;

  // Field widths.
  localparam int ANGLE_W    = 16;
  localparam int DIFF_W     = 17;
  localparam int WRAP_W     = 18;
  localparam int MAG_W      = 15;
  localparam int NUM_W      = 23;
  localparam int DVS_W      = 16;
  localparam int QUO_W      = 7;
  localparam int PCT_W      = 8;
  localparam int UPCT_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_USE_JOYSTICK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_VALID  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_CENTER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_CENTER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_DEADZONE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_FULLSCALE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PED_DEADZONE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PED_FULLSCALE = 3'd7;

  // Register reset values.
  localparam logic [MAG_W-1:0] DIR_DEADZONE_RST  = 15'd1000;
  localparam logic [MAG_W-1:0] DIR_FULLSCALE_RST = 15'd9000;
  localparam logic [MAG_W-1:0] PED_DEADZONE_RST  = 15'd1500;
  localparam logic [MAG_W-1:0] PED_FULLSCALE_RST = 15'd4500;

  // Angle wrap limits in hundredths of a degree.
  localparam logic signed [WRAP_W-1:0] HALF_TURN     = 18'sd18000;
  localparam logic signed [WRAP_W-1:0] FULL_TURN     = 18'sd36000;
  localparam logic signed [WRAP_W-1:0] THREE_HALF    = 18'sd54000;
  localparam logic signed [WRAP_W-1:0] TWO_TURN      = 18'sd72000;

  // Percent scaling.
  localparam logic [7:0] PCT_SCALE2 = 8'd200;
  localparam logic signed [ANGLE_W-1:0] PCT_MAX16 = 16'sd100;
  localparam logic signed [PCT_W-1:0]   PCT_MAX   = 8'sd100;

  // Per-item control that travels beside the lane data.
  typedef struct packed {
    logic                    tilt;
    logic [1:0]              neg;
    logic signed [PCT_W-1:0] dir_js;
    logic signed [PCT_W-1:0] ped_js;
  } side_t;

  // Clamp a joystick percentage to plus or minus 100.
  function automatic logic signed [PCT_W-1:0] clamp_pct(
      input logic signed [ANGLE_W-1:0] v);
    logic signed [PCT_W-1:0] r;
    if (v < -PCT_MAX16) begin
      r = -PCT_MAX;
    end else if (v > PCT_MAX16) begin
      r = PCT_MAX;
    end else begin
      r = v[PCT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/tjcm_in_if.sv */
// Input channel of the control mapper: valid/ready plus one sample item.
// Depends on tjcm_pkg for field widths.
`default_nettype none

interface tjcm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tjcm_pkg::ANGLE_W-1:0]  roll_angle;
  logic signed [tjcm_pkg::ANGLE_W-1:0]  pitch_angle;
  logic signed [tjcm_pkg::ANGLE_W-1:0]  stick_steer_pct;
  logic signed [tjcm_pkg::ANGLE_W-1:0]  stick_pedal_pct;

  modport source (output valid, roll_angle, pitch_angle, stick_steer_pct,
                  stick_pedal_pct, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, stick_steer_pct,
                  stick_pedal_pct, output ready);
endinterface

`default_nettype wire

/* hdl/tjcm_out_if.sv */
// Output channel of the control mapper: valid/ready plus one command item.
// Depends on tjcm_pkg for field widths.
`default_nettype none

interface tjcm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [tjcm_pkg::PCT_W-1:0]  steer_cmd;
  logic [tjcm_pkg::UPCT_W-1:0]        throttle_cmd;
  logic [tjcm_pkg::UPCT_W-1:0]        brake_cmd;

  modport source (output valid, steer_cmd, throttle_cmd, brake_cmd,
                  input ready);
  modport sink   (input valid, steer_cmd, throttle_cmd, brake_cmd,
                  output ready);
endinterface

`default_nettype wire

/* hdl/tilt_joystick_control_mapper_core.sv */
// Tilt/joystick control mapper, pipelined: wrap, deadzone, scale, divide.
// Depends on tjcm_pkg, tjcm_in_if and tjcm_out_if.
// Throughput: one item per cycle while out_if.ready does not hold it back;
// each of the 12 stages holds one item and the seven-stage restoring
// divider (one quotient bit per stage) sets depth.
// Reset clears all stage valid bits and loads the register reset values.
`default_nettype none

module tilt_joystick_control_mapper_core (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire [tjcm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [tjcm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  tjcm_in_if.sink                           in_if,
  tjcm_out_if.source                        out_if
);
  import tjcm_pkg::*;

  // Stage map: 0 difference, 1 wrap and magnitude, 2 deadzone and span,
  // 3 numerator, 4..10 divider bits, 11 output register.
  localparam int DIV0 = 3;
  localparam int NST  = QUO_W + 5;

  // Configuration registers.
  logic                     use_js_q;
  logic                     center_valid_q;
  logic signed [ANGLE_W-1:0] roll_center_q;
  logic signed [ANGLE_W-1:0] pitch_center_q;
  logic [MAG_W-1:0]         dir_dz_q;
  logic [MAG_W-1:0]         dir_fs_q;
  logic [MAG_W-1:0]         ped_dz_q;
  logic [MAG_W-1:0]         ped_fs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_js_q       <= 1'b0;
      center_valid_q <= 1'b0;
      roll_center_q  <= '0;
      pitch_center_q <= '0;
      dir_dz_q       <= DIR_DEADZONE_RST;
      dir_fs_q       <= DIR_FULLSCALE_RST;
      ped_dz_q       <= PED_DEADZONE_RST;
      ped_fs_q       <= PED_FULLSCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_USE_JOYSTICK:  use_js_q       <= cfg_wdata_i[0];
        CFG_CENTER_VALID:  center_valid_q <= cfg_wdata_i[0];
        CFG_ROLL_CENTER:   roll_center_q  <= cfg_wdata_i;
        CFG_PITCH_CENTER:  pitch_center_q <= cfg_wdata_i;
        CFG_DIR_DEADZONE:  dir_dz_q       <= cfg_wdata_i[MAG_W-1:0];
        CFG_DIR_FULLSCALE: dir_fs_q       <= cfg_wdata_i[MAG_W-1:0];
        CFG_PED_DEADZONE:  ped_dz_q       <= cfg_wdata_i[MAG_W-1:0];
        CFG_PED_FULLSCALE: ped_fs_q       <= cfg_wdata_i[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  // Lane 0 is roll (direction), lane 1 is pitch (pedal).
  logic [MAG_W-1:0] dz [2];
  logic [MAG_W-1:0] fs [2];
  assign dz[0] = dir_dz_q;
  assign dz[1] = ped_dz_q;
  assign fs[0] = dir_fs_q;
  assign fs[1] = ped_fs_q;

  // Handshake: each stage takes an item when it is empty or its item moves on.
  logic [NST-1:0] valid_q;
  logic [NST:0]   rdy;
  logic [NST-1:0] vin;

  always_comb begin
    rdy[NST] = out_if.ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    vin[0] = in_if.valid;
    for (int k = 1; k < NST; k++) begin
      vin[k] = valid_q[k-1];
    end
  end

  assign in_if.ready  = rdy[0];
  assign out_if.valid = valid_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= vin[k];
        end
      end
    end
  end

  // Sideband registers for stages 0 through NST-2.
  side_t sb_q [NST-1];
  side_t sb_d [NST-1];

  // Lane payload registers.
  logic signed [DIFF_W-1:0] diff_q [2];
  logic signed [DIFF_W-1:0] diff_d [2];
  logic [MAG_W-1:0]         mag_q  [2];
  logic [MAG_W-1:0]         mag_d  [2];
  logic [1:0]               neg_d;
  logic [MAG_W-1:0]         a_q    [2];
  logic [MAG_W-1:0]         a_d    [2];
  logic [MAG_W-1:0]         den_q  [2];
  logic [MAG_W-1:0]         den_d  [2];
  logic [NUM_W-1:0]         rem_q  [QUO_W+1][2];
  logic [NUM_W-1:0]         rem_d  [QUO_W+1][2];
  logic [DVS_W-1:0]         dvs_q  [QUO_W+1][2];
  logic [DVS_W-1:0]         dvs_d  [QUO_W+1][2];
  logic [QUO_W-1:0]         quo_q  [QUO_W+1][2];
  logic [QUO_W-1:0]         quo_d  [QUO_W+1][2];

  // Stage 0: angle minus center.
  always_comb begin
    diff_d[0] = {in_if.roll_angle[ANGLE_W-1], in_if.roll_angle}
              - {roll_center_q[ANGLE_W-1], roll_center_q};
    diff_d[1] = {in_if.pitch_angle[ANGLE_W-1], in_if.pitch_angle}
              - {pitch_center_q[ANGLE_W-1], pitch_center_q};
  end

  // Stage 1: wrap into half a turn either way, then split sign and magnitude.
  always_comb begin
    logic signed [WRAP_W-1:0] d;
    logic signed [WRAP_W-1:0] w;
    logic signed [WRAP_W-1:0] m;
    for (int l = 0; l < 2; l++) begin
      d = {diff_q[l][DIFF_W-1], diff_q[l]};
      if (d > THREE_HALF) begin
        w = d - TWO_TURN;
      end else if (d > HALF_TURN) begin
        w = d - FULL_TURN;
      end else if (d < -THREE_HALF) begin
        w = d + TWO_TURN;
      end else if (d < -HALF_TURN) begin
        w = d + FULL_TURN;
      end else begin
        w = d;
      end
      m        = (w < 0) ? -w : w;
      mag_d[l] = m[MAG_W-1:0];
      neg_d[l] = (w < 0);
    end
  end

  // Stage 2: deadzone and saturation. A dead or degenerate case divides 1 by 2,
  // which gives a zero quotient.
  always_comb begin
    logic [MAG_W-1:0] m;
    for (int l = 0; l < 2; l++) begin
      m = (mag_q[l] > fs[l]) ? fs[l] : mag_q[l];
      if (mag_q[l] <= dz[l] || fs[l] <= dz[l]) begin
        a_d[l]   = '0;
        den_d[l] = MAG_W'(1);
      end else begin
        a_d[l]   = m - dz[l];
        den_d[l] = fs[l] - dz[l];
      end
    end
  end

  // Stage 3 sets up the numerator 200*a + span and the divisor 2*span for
  // round-half-up; the divider stages then take one quotient bit each, most
  // significant first.
  always_comb begin
    logic [NUM_W-1:0] shifted;
    logic             ge;
    for (int l = 0; l < 2; l++) begin
      rem_d[0][l] = NUM_W'(a_q[l]) * NUM_W'(PCT_SCALE2) + NUM_W'(den_q[l]);
      dvs_d[0][l] = {den_q[l], 1'b0};
      quo_d[0][l] = '0;
    end
    for (int j = 1; j <= QUO_W; j++) begin
      for (int l = 0; l < 2; l++) begin
        shifted     = NUM_W'(dvs_q[j-1][l]) << (QUO_W - j);
        ge          = rem_q[j-1][l] >= shifted;
        rem_d[j][l] = ge ? rem_q[j-1][l] - shifted : rem_q[j-1][l];
        dvs_d[j][l] = dvs_q[j-1][l];
        quo_d[j][l] = quo_q[j-1][l] | (ge ? (QUO_W'(1) << (QUO_W - j)) : '0);
      end
    end
  end

  // Sideband: mode and joystick fallback values at entry, lane signs after
  // the wrap, and from stage 2 on it simply follows the item.
  always_comb begin
    sb_d[0].tilt   = !use_js_q && center_valid_q;
    sb_d[0].neg    = 2'b00;
    sb_d[0].dir_js = use_js_q ? clamp_pct(in_if.stick_steer_pct) : '0;
    sb_d[0].ped_js = use_js_q ? clamp_pct(in_if.stick_pedal_pct) : '0;
    sb_d[1]        = sb_q[0];
    sb_d[1].neg    = neg_d;
    for (int k = 2; k < NST - 1; k++) begin
      sb_d[k] = sb_q[k-1];
    end
  end

  // Payload registers load whenever their stage takes an item.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST - 1; k++) begin
      if (rdy[k]) begin
        sb_q[k] <= sb_d[k];
      end
    end
    for (int l = 0; l < 2; l++) begin
      if (rdy[0]) begin
        diff_q[l] <= diff_d[l];
      end
      if (rdy[1]) begin
        mag_q[l] <= mag_d[l];
      end
      if (rdy[2]) begin
        a_q[l]   <= a_d[l];
        den_q[l] <= den_d[l];
      end
      for (int j = 0; j <= QUO_W; j++) begin
        if (rdy[DIV0 + j]) begin
          rem_q[j][l] <= rem_d[j][l];
          dvs_q[j][l] <= dvs_d[j][l];
          quo_q[j][l] <= quo_d[j][l];
        end
      end
    end
  end

  // Output stage: apply signs, choose source, split pedal into two commands.
  side_t                    sb_last;
  logic signed [PCT_W-1:0]  dir_q, dir_d;
  logic [UPCT_W-1:0]        thr_q, thr_d;
  logic [UPCT_W-1:0]        brk_q, brk_d;

  assign sb_last = sb_q[NST-2];

  always_comb begin
    logic signed [PCT_W-1:0] qd;
    logic signed [PCT_W-1:0] qp;
    logic signed [PCT_W-1:0] neg_ped;
    qd      = $signed({1'b0, quo_q[QUO_W][0]});
    qp      = $signed({1'b0, quo_q[QUO_W][1]});
    neg_ped = -sb_last.ped_js;
    if (sb_last.tilt) begin
      dir_d = sb_last.neg[0] ? -qd : qd;
      thr_d = sb_last.neg[1] ? '0 : quo_q[QUO_W][1];
      brk_d = sb_last.neg[1] ? quo_q[QUO_W][1] : '0;
    end else begin
      dir_d = sb_last.dir_js;
      thr_d = (sb_last.ped_js > 0) ? sb_last.ped_js[UPCT_W-1:0] : '0;
      brk_d = (sb_last.ped_js < 0) ? neg_ped[UPCT_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NST-1]) begin
      dir_q <= dir_d;
      thr_q <= thr_d;
      brk_q <= brk_d;
    end
  end

  assign out_if.steer_cmd    = dir_q;
  assign out_if.throttle_cmd = thr_q;
  assign out_if.brake_cmd    = brk_q;

  // Throttle and brake never act together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.throttle_cmd == '0 || out_if.brake_cmd == '0))
    else $error("throttle and brake both nonzero");

  // Every command stays within plus or minus 100 percent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.steer_cmd <= PCT_MAX &&
                      out_if.steer_cmd >= -PCT_MAX &&
                      out_if.throttle_cmd <= UPCT_W'(100) &&
                      out_if.brake_cmd <= UPCT_W'(100)))
    else $error("command out of range");

  // An accepted item occupies the first stage in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> valid_q[0])
    else $error("accepted item lost at first stage");

endmodule

`default_nettype wire

/* test/tilt_joystick_control_mapper_core_tb.sv */
// Self-checking testbench for tilt_joystick_control_mapper_core: drives samples
// and register writes, predicts every steering/throttle/brake command and checks it.
// Depends on tjcm_pkg, tjcm_in_if, tjcm_out_if and the core itself.
module tilt_joystick_control_mapper_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tjcm_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int PIPE_LATENCY = 12;
  localparam int HOLD_CYCLES  = 100;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RAND_PHASES  = 16;
  localparam int PHASE_ITEMS  = 100;
  localparam int ANGLE_MAX    = 18000;

  // One sample item and one command item.
  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] stick_steer_pct;
    logic signed [ANGLE_W-1:0] stick_pedal_pct;
  } sample_t;

  typedef struct packed {
    logic signed [PCT_W-1:0] steer_cmd;
    logic [UPCT_W-1:0]       throttle_cmd;
    logic [UPCT_W-1:0]       brake_cmd;
  } cmd_t;

  // One full set of register values.
  typedef struct {
    bit                        joystick;
    bit                        calibrated;
    logic signed [ANGLE_W-1:0] roll_ctr;
    logic signed [ANGLE_W-1:0] pitch_ctr;
    logic [MAG_W-1:0]          dir_dz;
    logic [MAG_W-1:0]          dir_fs;
    logic [MAG_W-1:0]          ped_dz;
    logic [MAG_W-1:0]          ped_fs;
  } mapper_settings_t;

  // Mirror of the registers plus the queue of commands still owed by the core.
  class mapper_scoreboard;
    bit                        joystick_mode;
    bit                        center_valid;
    logic signed [ANGLE_W-1:0] roll_ctr;
    logic signed [ANGLE_W-1:0] pitch_ctr;
    logic [MAG_W-1:0]          dir_dz;
    logic [MAG_W-1:0]          dir_fs;
    logic [MAG_W-1:0]          ped_dz;
    logic [MAG_W-1:0]          ped_fs;
    cmd_t                      cmd_q[$];
    int unsigned               fail_count;

    function new();
      joystick_mode = 1'b0;
      center_valid  = 1'b0;
      roll_ctr      = '0;
      pitch_ctr     = '0;
      dir_dz        = DIR_DEADZONE_RST;
      dir_fs        = DIR_FULLSCALE_RST;
      ped_dz        = PED_DEADZONE_RST;
      ped_fs        = PED_FULLSCALE_RST;
      fail_count    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_USE_JOYSTICK:  joystick_mode = data[0];
        CFG_CENTER_VALID:  center_valid  = data[0];
        CFG_ROLL_CENTER:   roll_ctr      = data;
        CFG_PITCH_CENTER:  pitch_ctr     = data;
        CFG_DIR_DEADZONE:  dir_dz        = data[MAG_W-1:0];
        CFG_DIR_FULLSCALE: dir_fs        = data[MAG_W-1:0];
        CFG_PED_DEADZONE:  ped_dz        = data[MAG_W-1:0];
        CFG_PED_FULLSCALE: ped_fs        = data[MAG_W-1:0];
        default: ;
      endcase
    endfunction

    // Bring an angle difference back into one turn; a half turn is kept as is.
    function int wrap_angle(int d);
      while (d > ANGLE_MAX) d -= 2 * ANGLE_MAX;
      while (d < -ANGLE_MAX) d += 2 * ANGLE_MAX;
      return d;
    endfunction

    // Deadzone, saturation and round-half-up scaling to a signed percent.
    function int axis_percent(int delta, int dz, int fs);
      longint mag;
      longint num;
      longint den;
      longint pct;
      mag = (delta < 0) ? -longint'(delta) : longint'(delta);
      if (mag <= dz || fs <= dz) return 0;
      if (mag > fs) mag = fs;
      num = (mag - dz) * 100;
      den = fs - dz;
      pct = (2 * num + den) / (2 * den);
      return (delta < 0) ? -int'(pct) : int'(pct);
    endfunction

    function cmd_t predict_command(sample_t s);
      int   steer;
      int   pedal;
      cmd_t c;
      steer = 0;
      pedal = 0;
      if (joystick_mode) begin
        steer = int'(s.stick_steer_pct);
        pedal = int'(s.stick_pedal_pct);
      end else if (center_valid) begin
        steer = axis_percent(wrap_angle(int'(s.roll_angle) - int'(roll_ctr)),
                             int'(dir_dz), int'(dir_fs));
        pedal = axis_percent(wrap_angle(int'(s.pitch_angle) - int'(pitch_ctr)),
                             int'(ped_dz), int'(ped_fs));
      end
      // Both axes are limited to plus or minus 100 percent.
      if (steer > 100) steer = 100;
      if (steer < -100) steer = -100;
      if (pedal > 100) pedal = 100;
      if (pedal < -100) pedal = -100;
      c.steer_cmd    = PCT_W'(steer);
      c.throttle_cmd = (pedal > 0) ? UPCT_W'(pedal) : '0;
      c.brake_cmd    = (pedal < 0) ? UPCT_W'(-pedal) : '0;
      return c;
    endfunction

    function void note_sample(sample_t s);
      cmd_q.push_back(predict_command(s));
    endfunction

    function void check_command(cmd_t got);
      cmd_t want;
      if (cmd_q.size() == 0) begin
        $error("unexpected command: steer_cmd %0d, throttle_cmd %0d, brake_cmd %0d",
               got.steer_cmd, got.throttle_cmd, got.brake_cmd);
        fail_count++;
        return;
      end
      want = cmd_q.pop_front();
      if (got.steer_cmd !== want.steer_cmd) begin
        $error("steer_cmd: expected %0d, got %0d", want.steer_cmd, got.steer_cmd);
        fail_count++;
      end
      if (got.throttle_cmd !== want.throttle_cmd) begin
        $error("throttle_cmd: expected %0d, got %0d", want.throttle_cmd, got.throttle_cmd);
        fail_count++;
      end
      if (got.brake_cmd !== want.brake_cmd) begin
        $error("brake_cmd: expected %0d, got %0d", want.brake_cmd, got.brake_cmd);
        fail_count++;
      end
    endfunction

    function int unsigned pending();
      return cmd_q.size();
    endfunction
  endclass

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  bit src_gaps_on    = 1'b0;
  bit sink_stalls_on = 1'b0;
  bit hold_req       = 1'b0;

  mapper_scoreboard sb = new();

  tjcm_in_if  in_ch ();
  tjcm_out_if out_ch ();

  tilt_joystick_control_mapper_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Monitors: predict on every accepted sample, check every accepted command.
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      sb.note_sample('{roll_angle: in_ch.roll_angle, pitch_angle: in_ch.pitch_angle,
                       stick_steer_pct: in_ch.stick_steer_pct,
                       stick_pedal_pct: in_ch.stick_pedal_pct});
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      sb.check_command('{steer_cmd: out_ch.steer_cmd,
                         throttle_cmd: out_ch.throttle_cmd,
                         brake_cmd: out_ch.brake_cmd});
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin : sink_driver
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (sink_stalls_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // Watchdog: ends the run when no item moves on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  // Offer one sample, with an occasional idle burst first, until it is taken.
  task automatic send_sample(input sample_t s);
    if (src_gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.roll_angle      <= s.roll_angle;
    in_ch.pitch_angle     <= s.pitch_angle;
    in_ch.stick_steer_pct <= s.stick_steer_pct;
    in_ch.stick_pedal_pct <= s.stick_pedal_pct;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_fields(input int roll, input int pitch, input int steer, input int pedal);
    send_sample('{ANGLE_W'(roll), ANGLE_W'(pitch), ANGLE_W'(steer), ANGLE_W'(pedal)});
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
  endtask

  // Wait until every owed command has come back, then let the pipe settle.
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Registers change only with the core empty.
  task automatic apply_settings(input mapper_settings_t st);
    wait_drained();
    write_register(CFG_USE_JOYSTICK, CFG_DATA_W'(st.joystick));
    write_register(CFG_CENTER_VALID, CFG_DATA_W'(st.calibrated));
    write_register(CFG_ROLL_CENTER, st.roll_ctr);
    write_register(CFG_PITCH_CENTER, st.pitch_ctr);
    write_register(CFG_DIR_DEADZONE, CFG_DATA_W'(st.dir_dz));
    write_register(CFG_DIR_FULLSCALE, CFG_DATA_W'(st.dir_fs));
    write_register(CFG_PED_DEADZONE, CFG_DATA_W'(st.ped_dz));
    write_register(CFG_PED_FULLSCALE, CFG_DATA_W'(st.ped_fs));
    cfg_we_i <= 1'b0;
  endtask

  // Angle aimed at the interesting spots around the current center.
  function automatic logic signed [ANGLE_W-1:0] tilt_angle(int ctr, int dz, int fs);
    int a;
    int sgn;
    sgn = ($urandom_range(0, 1) != 0) ? 1 : -1;
    case ($urandom_range(0, 5))
      0, 1: a = int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
      2: a = ctr + sgn * (dz + int'($urandom_range(0, 4)) - 2);
      3: a = ctr + sgn * (fs + int'($urandom_range(0, 4)) - 2);
      4: a = ctr + int'($urandom_range(0, 2 * dz + 2)) - dz - 1;
      default: a = sgn * ANGLE_MAX;
    endcase
    // Fold back into the legal angle range; the difference stays the same modulo a turn.
    while (a > ANGLE_MAX) a -= 2 * ANGLE_MAX;
    while (a < -ANGLE_MAX) a += 2 * ANGLE_MAX;
    return ANGLE_W'(a);
  endfunction

  function automatic logic signed [ANGLE_W-1:0] stick_value();
    case ($urandom_range(0, 3))
      0: return ANGLE_W'($urandom_range(0, 65535));
      1: return ANGLE_W'(int'($urandom_range(0, 204)) - 102);
      2: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
      default: return ANGLE_W'(int'($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.roll_angle      = tilt_angle(int'(sb.roll_ctr), int'(sb.dir_dz), int'(sb.dir_fs));
    s.pitch_angle     = tilt_angle(int'(sb.pitch_ctr), int'(sb.ped_dz), int'(sb.ped_fs));
    s.stick_steer_pct = stick_value();
    s.stick_pedal_pct = stick_value();
    return s;
  endfunction

  // Deadzone and full scale pair: wide, tight, extreme or degenerate.
  function automatic void pick_span(output logic [MAG_W-1:0] dz, output logic [MAG_W-1:0] fs);
    int d;
    int f;
    case ($urandom_range(0, 5))
      0: begin
        d = 0;
        f = ANGLE_MAX;
      end
      1: begin
        d = $urandom_range(0, ANGLE_MAX);
        f = $urandom_range(0, d);
      end
      2: begin
        d = $urandom_range(0, 500);
        f = d + int'($urandom_range(1, 200));
      end
      default: begin
        d = $urandom_range(0, 9000);
        f = d + int'($urandom_range(1, ANGLE_MAX - d));
      end
    endcase
    dz = MAG_W'(d);
    fs = MAG_W'(f);
  endfunction

  function automatic mapper_settings_t random_settings();
    mapper_settings_t st;
    st.joystick   = ($urandom_range(0, 3) == 0);
    st.calibrated = ($urandom_range(0, 4) != 0);
    st.roll_ctr   = ANGLE_W'(int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX);
    st.pitch_ctr  = ANGLE_W'(int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX);
    pick_span(st.dir_dz, st.dir_fs);
    pick_span(st.ped_dz, st.ped_fs);
    return st;
  endfunction

  initial begin : stimulus
    int unsigned phase;
    in_ch.valid           <= 1'b0;
    in_ch.roll_angle      <= '0;
    in_ch.pitch_angle     <= '0;
    in_ch.stick_steer_pct <= '0;
    in_ch.stick_pedal_pct <= '0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= CFG_USE_JOYSTICK;
    cfg_wdata_i           <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;

    // Out of reset the core is in tilt mode without calibration: all zero.
    send_fields(18000, -18000, 100, -100);
    send_fields(-18000, 18000, -32768, 32767);
    stop_sending();

    // Calibrated at zero with the default spans: deadzone edges, rounding, saturation.
    apply_settings('{0, 1, 0, 0, 1000, 9000, 1500, 4500});
    send_fields(0, 0, 55, -55);
    send_fields(1000, 1500, 0, 0);
    send_fields(-1001, -1501, 0, 0);
    send_fields(1040, -1515, 0, 0);
    send_fields(9000, 4500, 0, 0);
    send_fields(-17999, -4501, 0, 0);
    stop_sending();

    // Centers at the extremes: differences of a full turn, a half turn and beyond.
    apply_settings('{0, 1, 18000, -18000, 0, 18000, 0, 18000});
    send_fields(-18000, 18000, 0, 0);
    send_fields(0, 0, 0, 0);
    send_fields(1, -1, 0, 0);
    send_fields(17999, -17999, 0, 0);
    send_fields(-17999, 17999, 0, 0);
    stop_sending();

    // Full scale not above the deadzone gives zero whatever the angle.
    apply_settings('{0, 1, -18000, 18000, 18000, 18000, 500, 0});
    send_fields(0, 0, 0, 0);
    send_fields(18000, -18000, 0, 0);
    send_fields(-18000, 17999, 0, 0);
    stop_sending();

    // Joystick mode: limits of the stick fields and the clamp boundaries.
    apply_settings('{1, 0, 0, 0, 1000, 9000, 1500, 4500});
    send_fields(18000, 18000, 32767, -32768);
    send_fields(-18000, -18000, -32768, 32767);
    send_fields(0, 0, 100, -100);
    send_fields(0, 0, 101, -101);
    send_fields(0, 0, -101, 101);
    send_fields(0, 0, 0, -1);
    send_fields(0, 0, -1, 0);
    stop_sending();

    // Random phases, each under its own register setting; the tail runs without idling.
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      apply_settings(random_settings());
      src_gaps_on    = (phase < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
      sink_stalls_on = (phase < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
      // Midway the receiver holds off while samples keep coming, so the core backs up.
      if (phase == RAND_PHASES / 2) hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_sample(random_sample());
      stop_sending();
    end

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 8) @(posedge clk_i);
    if (sb.fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/tjcm_pkg.sv
hdl/tjcm_in_if.sv
hdl/tjcm_out_if.sv
hdl/tilt_joystick_control_mapper_core.sv
test/tilt_joystick_control_mapper_core_tb.sv
